[design/assert_macros.svh]
// assertion macros shared by the hash block rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define WMXH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define WMXH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/wmxh_pkg.sv]
// types, constants and register codes for the word multiply xor byte hash
// no dependencies; imported by every module of the block
package wmxh_pkg;

    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int PART_W    = 24;
    localparam int CNT_W     = $clog2(WORD_W);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 2'd2;

    localparam logic [WORD_W-1:0] SEED_RST  = 32'd0;
    localparam logic [WORD_W-1:0] PRIME_RST = 32'd1;
    localparam logic [WORD_W-1:0] RANGE_RST = 32'd0;

    typedef enum logic {
        ALU_MUL,
        ALU_MOD
    } t_alu_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_MOD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] prime;
        logic [WORD_W-1:0] range;
    } t_cfg;

    typedef struct packed {
        logic              start;
        t_alu_op           op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_stat;

endpackage

[design/wmxh_cfg.sv]
// configuration register file: seed, prime and range
// depends on wmxh_pkg
module wmxh_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wmxh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wmxh_pkg::WORD_W-1:0]        i_cfg_data,
    output wmxh_pkg::t_cfg                     o_cfg
);
    import wmxh_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed  <= SEED_RST;
            r_cfg.prime <= PRIME_RST;
            r_cfg.range <= RANGE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SEED:  r_cfg.seed  <= i_cfg_data;
                CFG_PRIME: r_cfg.prime <= i_cfg_data;
                CFG_RANGE: r_cfg.range <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[design/wmxh_alu.sv]
// shared shift-add multiplier (low word) and restoring remainder unit
// one bit per cycle through a single adder; depends on wmxh_pkg
`include "assert_macros.svh"

module wmxh_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wmxh_pkg::t_alu_req            i_req,
    output wmxh_pkg::t_alu_stat           o_stat,
    output logic [wmxh_pkg::WORD_W-1:0]   o_res
);
    import wmxh_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    t_alu_op           r_op;
    logic [WORD_W-1:0] r_x;
    logic [WORD_W-1:0] r_y;
    logic [WORD_W-1:0] r_z;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   add_x;
    logic [WORD_W:0]   add_y;
    logic              add_sub;
    logic [WORD_W+1:0] add_res;
    logic [WORD_W-1:0] n_x;

    assign rem_sh = {r_x, r_z[WORD_W-1]};

    // the one shared adder
    always_comb begin
        if (r_op == ALU_MOD) begin
            add_x   = rem_sh;
            add_y   = {1'b0, r_y};
            add_sub = 1'b1;
        end else begin
            add_x   = {1'b0, r_x};
            add_y   = {1'b0, r_y};
            add_sub = 1'b0;
        end
        add_res = {1'b0, add_x} + ({1'b0, add_y} ^ {(WORD_W+2){add_sub}})
                + {{(WORD_W+1){1'b0}}, add_sub};
    end

    always_comb begin
        if (r_op == ALU_MOD) begin
            n_x = add_res[WORD_W+1] ? rem_sh[WORD_W-1:0] : add_res[WORD_W-1:0];
        end else begin
            n_x = r_z[0] ? add_res[WORD_W-1:0] : r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ALU_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_op   <= i_req.op;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= '0;
            r_y <= (i_req.op == ALU_MUL) ? i_req.a : i_req.b;
            r_z <= (i_req.op == ALU_MUL) ? i_req.b : i_req.a;
        end else if (r_busy) begin
            r_x <= n_x;
            if (r_op == ALU_MUL) begin
                r_y <= {r_y[WORD_W-2:0], 1'b0};
                r_z <= {1'b0, r_z[WORD_W-1:1]};
            end else begin
                r_z <= {r_z[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_x;

    `WMXH_ASSERT_SAME(a_start_idle, i_clk, i_rst_n, i_req.start, !r_busy, "alu start while busy")
    `WMXH_ASSERT_NEXT(a_done_after_run, i_clk, i_rst_n, r_busy && !i_req.start && (r_cnt == CNT_W'(WORD_W - 1)), r_done && !r_busy, "alu run did not finish")

endmodule

[design/word_multiply_xor_byte_hash.sv]
// byte stream hash: bytes packed msb first into words, acc = acc * prime ^ word
// a byte that neither completes a word nor ends the message is packed into the partial word; a byte that
// completes a word starts a 32-step shift-add multiply in the shared alu
// a last byte does the same, and with a nonzero range the product is then reduced by a remainder
// in the shared alu; an empty beat gives hash 0; held output stalls
// synchronous active-low reset: registers seed 0, prime 1, range 0, no message in progress
`include "assert_macros.svh"

module word_multiply_xor_byte_hash (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [wmxh_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] data_byte
    input  logic                               s_tlast,
    input  logic                               s_tuser,   // [0] empty_message
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [wmxh_pkg::WORD_W-1:0]        m_tdata,   // [31:0] hash_value
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wmxh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wmxh_pkg::WORD_W-1:0]        i_cfg_data
);
    import wmxh_pkg::*;

    t_cfg        cfg;
    t_alu_req    alu_req;
    t_alu_stat   alu_stat;
    logic [WORD_W-1:0] alu_res;

    t_state            r_state,    n_state;
    logic              r_in_msg,   n_in_msg;
    logic [1:0]        r_bytes,    n_bytes;
    logic [PART_W-1:0] r_partial,  n_partial;
    logic [WORD_W-1:0] r_acc,      n_acc;
    logic [WORD_W-1:0] r_word,     n_word;
    logic              r_last,     n_last;
    logic [WORD_W-1:0] r_res,      n_res;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_data,  n_out_data;

    logic [WORD_W-1:0] acc_base;
    logic [WORD_W-1:0] word_in;
    logic [WORD_W-1:0] acc_new;
    logic              emit_go;

    wmxh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wmxh_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_stat  (alu_stat),
        .o_res   (alu_res)
    );

    assign acc_base = r_in_msg ? r_acc : cfg.seed;
    assign acc_new  = alu_res ^ r_word;
    assign emit_go  = (r_state == S_EMIT) && (!r_out_valid || m_tready);

    // word with the new byte, left aligned and zero padded
    always_comb begin
        case (r_bytes)
            2'd0:    word_in = {s_tdata, 24'd0};
            2'd1:    word_in = {r_partial[7:0], s_tdata, 16'd0};
            2'd2:    word_in = {r_partial[15:0], s_tdata, 8'd0};
            default: word_in = {r_partial, s_tdata};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_msg    <= 1'b0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_msg    <= n_in_msg;
            r_bytes     <= n_bytes;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_partial  <= n_partial;
        r_acc      <= n_acc;
        r_word     <= n_word;
        r_last     <= n_last;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_in_msg    = r_in_msg;
        n_bytes     = r_bytes;
        n_partial   = r_partial;
        n_acc       = r_acc;
        n_word      = r_word;
        n_last      = r_last;
        n_res       = r_res;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_MUL;
        alu_req.a     = acc_base;
        alu_req.b     = cfg.prime;
        s_tready    = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        n_in_msg = 1'b0;
                        n_bytes  = '0;
                        n_res    = '0;
                        n_state  = S_EMIT;
                    end else begin
                        n_in_msg = 1'b1;
                        n_acc    = acc_base;
                        if ((r_bytes == 2'd3) || s_tlast) begin
                            alu_req.start = 1'b1;
                            n_word        = word_in;
                            n_last        = s_tlast;
                            n_bytes       = '0;
                            n_state       = S_MUL;
                        end else begin
                            n_partial = {r_partial[15:0], s_tdata};
                            n_bytes   = r_bytes + 2'd1;
                        end
                    end
                end
            end
            S_MUL: begin
                if (alu_stat.done) begin
                    n_acc = acc_new;
                    if (r_last) begin
                        n_in_msg = 1'b0;
                        if (cfg.range != '0) begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_MOD;
                            alu_req.a     = acc_new;
                            alu_req.b     = cfg.range;
                            n_state       = S_MOD;
                        end else begin
                            n_res   = acc_new;
                            n_state = S_EMIT;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MOD: begin
                if (alu_stat.done) begin
                    n_res   = alu_res;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && !m_tready;
        n_out_data  = r_out_data;
        if (emit_go) begin
            n_out_valid = 1'b1;
            n_out_data  = r_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    `WMXH_ASSERT_SAME(a_bytes_in_msg, i_clk, i_rst_n, r_bytes != 2'd0, r_in_msg, "partial word outside a message")
    `WMXH_ASSERT_SAME(a_mod_nonzero, i_clk, i_rst_n, alu_req.start && (alu_req.op == ALU_MOD), cfg.range != '0, "remainder by zero range")
    `WMXH_ASSERT_SAME(a_done_in_run, i_clk, i_rst_n, alu_stat.done, (r_state == S_MUL) || (r_state == S_MOD), "alu done outside a run state")

endmodule
